// File: rtl/dnsa_pkg.sv
package dnsa_pkg;

   // default sizing, overridden through the top level parameters
   localparam int MAX_ADDRESSES_DEF    = 4;
   localparam int MAX_PACKET_BYTES_DEF = 512;

   // queue between parser and result stage, power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // dns framing
   localparam logic [15:0] HDR_BYTES       = 16'd12;
   localparam logic [15:0] ANCOUNT_HI_BYTE = 16'd6;
   localparam logic [15:0] ANCOUNT_LO_BYTE = 16'd7;
   localparam logic [15:0] TYPE_CLASS_END  = 16'd4;
   localparam logic [15:0] RDLENGTH_START  = 16'd8;
   localparam logic [15:0] RR_FIXED_BYTES  = 16'd10;
   localparam logic [15:0] ADDR_BYTES      = 16'd4;
   localparam logic [7:0]  PTR_MASK        = 8'hc0;
   localparam logic [31:0] TYPE_A_CLASS_IN = 32'h0001_0001;
   localparam logic [31:0] A_RDLENGTH      = 32'd4;

   // configuration
   localparam int          CSR_ADDR_W      = 3;
   localparam logic [9:0]  MIN_QUERY_LEN   = 10'd12;
   localparam logic [0:0]  REG_QUERY_LENGTH = 1'b0;

   // result kinds
   localparam logic KIND_ADDR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      ST_OK,
      ST_TRUNC,
      ST_NOANS,
      ST_BADLEN
   } status_type;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_QSKIP,
      PH_NAME,
      PH_LABEL,
      PH_PTR,
      PH_RR,
      PH_ADDR,
      PH_RSKIP,
      PH_DONE
   } phase_type;

   // what one parsed request leaves for the result stage
   typedef struct packed {
      logic        has_addr;
      logic [31:0] addr;
      logic        has_status;
      status_type  status;
      logic [2:0]  count;
   } event_type;

endpackage

// File: rtl/dnsa_if.sv
interface dnsa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, data_byte, end_of_packet, input ready);
   modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface dnsa_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [31:0] ipv4_address;
   logic [1:0]  status;
   logic [2:0]  address_count;
   logic        last_result;

   modport source (output valid, result_kind, ipv4_address, status, address_count,
                   last_result, input ready);
   modport sink   (input valid, result_kind, ipv4_address, status, address_count,
                   last_result, output ready);
endinterface

// File: rtl/dnsa_front.sv
module dnsa_front import dnsa_pkg::*; #(
   parameter int MAX_ADDRESSES    = MAX_ADDRESSES_DEF,
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [9:0] query_length,
   dnsa_req_if.sink   req_bus,
   input  logic       queue_full,
   output logic       push_valid,
   output event_type  push_data
);

   localparam int StoreW = $clog2(MAX_ADDRESSES + 1);
   localparam int PktW   = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [StoreW-1:0] StoreMax = StoreW'(MAX_ADDRESSES);
   localparam logic [PktW-1:0]   PktMax   = PktW'(MAX_PACKET_BYTES);

   phase_type         phase_ff, phase_in;
   logic [15:0]       cnt_ff, cnt_in;
   logic [15:0]       ans_ff, ans_in;
   logic [31:0]       shift_ff, shift_in;
   logic [31:0]       tc_ff, tc_in;
   logic [StoreW-1:0] stored_ff, stored_in;
   status_type        err_ff, err_in;
   logic              done_ff, done_in;
   logic [PktW-1:0]   pbytes_ff, pbytes_in;

   logic        accept;
   logic [7:0]  b;
   logic        eop;
   logic        fin;
   status_type  fin_err;
   logic        rec_fin;
   logic        emit;
   logic [31:0] addr_word;
   logic [15:0] ans_dec;
   logic [9:0]  ql_eff;
   status_type  eop_status;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign eop           = req_bus.end_of_packet;
   assign ql_eff        = (query_length < MIN_QUERY_LEN) ? MIN_QUERY_LEN : query_length;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      ans_in    = ans_ff;
      shift_in  = shift_ff;
      tc_in     = tc_ff;
      stored_in = stored_ff;
      err_in    = err_ff;
      done_in   = done_ff;
      pbytes_in = pbytes_ff;
      fin       = 1'b0;
      fin_err   = ST_OK;
      rec_fin   = 1'b0;
      emit      = 1'b0;
      addr_word = {shift_ff[23:0], b};
      ans_dec   = ans_ff - 16'd1;

      if (!done_ff && pbytes_ff < PktMax) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (cnt_ff == ANCOUNT_HI_BYTE || cnt_ff == ANCOUNT_LO_BYTE) begin
                  ans_in = {ans_ff[7:0], b};
               end
               cnt_in = cnt_ff + 16'd1;
               if (cnt_in >= HDR_BYTES) begin
                  if (ans_in == 16'd0) begin
                     fin     = 1'b1;
                     fin_err = ST_NOANS;
                  end else begin
                     cnt_in   = {6'd0, ql_eff - MIN_QUERY_LEN};
                     phase_in = (ql_eff == MIN_QUERY_LEN) ? PH_NAME : PH_QSKIP;
                  end
               end
            end
            PH_QSKIP, PH_LABEL: begin
               cnt_in = cnt_ff - 16'd1;
               if (cnt_ff == 16'd1) begin
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               if (b == 8'd0) begin
                  phase_in = PH_RR;
                  cnt_in   = 16'd0;
                  shift_in = 32'd0;
                  tc_in    = 32'd0;
               end else if ((b & PTR_MASK) == PTR_MASK) begin
                  phase_in = PH_PTR;
               end else begin
                  phase_in = PH_LABEL;
                  cnt_in   = {8'd0, b};
               end
            end
            PH_PTR: begin
               phase_in = PH_RR;
               cnt_in   = 16'd0;
               shift_in = 32'd0;
               tc_in    = 32'd0;
            end
            PH_RR: begin
               if (cnt_ff < TYPE_CLASS_END) begin
                  tc_in = {tc_ff[23:0], b};
               end else if (cnt_ff >= RDLENGTH_START) begin
                  shift_in = {16'd0, shift_ff[7:0], b};
               end
               cnt_in = cnt_ff + 16'd1;
               if (cnt_in >= RR_FIXED_BYTES) begin
                  if (tc_in == TYPE_A_CLASS_IN) begin
                     if (shift_in != A_RDLENGTH) begin
                        fin     = 1'b1;
                        fin_err = ST_BADLEN;
                     end else begin
                        phase_in = PH_ADDR;
                        cnt_in   = 16'd0;
                        shift_in = 32'd0;
                     end
                  end else if (shift_in == 32'd0) begin
                     rec_fin = 1'b1;
                  end else begin
                     phase_in = PH_RSKIP;
                     cnt_in   = shift_in[15:0];
                  end
               end
            end
            PH_ADDR: begin
               shift_in = addr_word;
               cnt_in   = cnt_ff + 16'd1;
               if (cnt_in >= ADDR_BYTES) begin
                  if (stored_ff < StoreMax) begin
                     stored_in = stored_ff + StoreW'(1);
                     emit      = 1'b1;
                  end
                  rec_fin = 1'b1;
               end
            end
            PH_RSKIP: begin
               cnt_in = cnt_ff - 16'd1;
               if (cnt_ff == 16'd1) begin
                  rec_fin = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // record done: next answer or end of parsing
      if (rec_fin) begin
         ans_in = ans_dec;
         if (ans_dec == 16'd0) begin
            fin     = 1'b1;
            fin_err = ST_OK;
         end else begin
            phase_in = PH_NAME;
         end
      end

      // first error sticks
      if (fin) begin
         if (err_ff == ST_OK) begin
            err_in = fin_err;
         end
         done_in  = 1'b1;
         phase_in = PH_DONE;
      end

      if (pbytes_ff < PktMax) begin
         pbytes_in = pbytes_ff + PktW'(1);
      end

      eop_status = (err_in == ST_OK && !done_in) ? ST_TRUNC : err_in;

      push_valid = accept && (emit || eop);
      push_data  = '{has_addr: emit, addr: addr_word, has_status: eop,
                     status: eop_status, count: 3'(stored_in)};

      // packet state back to idle after the status
      if (eop) begin
         phase_in  = PH_HEADER;
         cnt_in    = 16'd0;
         ans_in    = 16'd0;
         shift_in  = 32'd0;
         tc_in     = 32'd0;
         stored_in = '0;
         err_in    = ST_OK;
         done_in   = 1'b0;
         pbytes_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         cnt_ff    <= 16'd0;
         ans_ff    <= 16'd0;
         shift_ff  <= 32'd0;
         tc_ff     <= 32'd0;
         stored_ff <= '0;
         err_ff    <= ST_OK;
         done_ff   <= 1'b0;
         pbytes_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         ans_ff    <= ans_in;
         shift_ff  <= shift_in;
         tc_ff     <= tc_in;
         stored_ff <= stored_in;
         err_ff    <= err_in;
         done_ff   <= done_in;
         pbytes_ff <= pbytes_in;
      end
   end

endmodule

// File: rtl/dnsa_queue.sv
module dnsa_queue import dnsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  event_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output event_type head
);

   event_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, rd_ff;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;

   assign full       = (fill_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push_valid && !pop) begin
         fill_in = fill_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push_valid) begin
            wr_ff <= wr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QUEUE_PTR_W'(1);
         end
         fill_ff <= fill_in;
      end
   end

endmodule

// File: rtl/dnsa_back.sv
module dnsa_back import dnsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  event_type head,
   output logic      pop,
   dnsa_rsp_if.source rsp_bus
);

   event_type cur_ff, cur_in;
   logic      take;
   logic      empty;
   logic      last_one;

   assign take     = rsp_bus.valid && rsp_bus.ready;
   assign empty    = !cur_ff.has_addr && !cur_ff.has_status;
   assign last_one = cur_ff.has_addr ^ cur_ff.has_status;
   assign pop      = head_valid && (empty || (take && last_one));

   always_comb begin
      cur_in = cur_ff;
      if (take) begin
         if (cur_ff.has_addr) begin
            cur_in.has_addr = 1'b0;
         end else begin
            cur_in.has_status = 1'b0;
         end
      end
      if (pop) begin
         cur_in = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.has_addr   <= 1'b0;
         cur_ff.has_status <= 1'b0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   // address item goes out ahead of the status item
   assign rsp_bus.valid         = !empty;
   assign rsp_bus.result_kind   = cur_ff.has_addr ? KIND_ADDR : KIND_STATUS;
   assign rsp_bus.ipv4_address  = cur_ff.has_addr ? cur_ff.addr : 32'd0;
   assign rsp_bus.status        = cur_ff.has_addr ? ST_OK : cur_ff.status;
   assign rsp_bus.address_count = cur_ff.count;
   assign rsp_bus.last_result   = !cur_ff.has_addr;

endmodule

// File: rtl/dns_a_response_parser.sv
// path: the event of an accepted request byte is written into the queue, then
//   loaded into the result register that drives the result port
// throughput: one request per cycle while the queue is not full; a request
//   yielding an address and the final status puts two items on the port, and a
//   four-entry queue before the result register absorbs that and downstream stalls
// reset: synchronous, active high; clears parser state, queue and result valid,
//   and sets query_length to 12
module dns_a_response_parser import dnsa_pkg::*; #(
   parameter int MAX_ADDRESSES    = MAX_ADDRESSES_DEF,
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dnsa_req_if.sink              req_bus,
   dnsa_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // configuration register, write only while the parser is idle; the block does not enforce it
   logic [9:0] query_length_ff;
   logic       csr_write;
   logic [0:0] csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff <= MIN_QUERY_LEN;
      end else if (csr_write && csr_index == REG_QUERY_LENGTH) begin
         query_length_ff <= pwdata[9:0];
      end
   end

   // reads beyond the register list return zero
   assign prdata = (csr_index == REG_QUERY_LENGTH) ? {22'd0, query_length_ff} : 32'd0;

   // parser front end: one request byte per cycle while the queue is not full,
   // pushes an event when the byte completes a stored address or ends the packet
   logic      push_valid;
   event_type push_data;
   logic      queue_full;

   dnsa_front #(
      .MAX_ADDRESSES    (MAX_ADDRESSES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .query_length (query_length_ff),
      .req_bus      (req_bus),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   // event queue, lets the parser run on while results wait
   logic      pop;
   logic      head_valid;
   event_type head;

   dnsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // result stage: splits an event into its address and status items
   dnsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: rtl/dnsa_checker.sv
module dnsa_checker import dnsa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_result_kind,
   input logic [31:0]           rsp_ipv4_address,
   input logic [1:0]            rsp_status,
   input logic [2:0]            rsp_address_count,
   input logic                  rsp_last_result,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [31:0]           pwdata,
   input logic [31:0]           prdata
);

   // nothing left to deliver after reset
   a_reset_rsp_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // queue empty after reset, so requests are taken
   a_reset_req_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   // query length reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[2] == REG_QUERY_LENGTH)
      |=> (paddr[2] != REG_QUERY_LENGTH || prdata[9:0] == $past(pwdata[9:0])))
      else $error("query length readback mismatch");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_kind)
      && $stable(rsp_ipv4_address) && $stable(rsp_status)
      && $stable(rsp_address_count) && $stable(rsp_last_result)))
      else $error("result changed while stalled");

endmodule

bind dns_a_response_parser dnsa_checker u_dnsa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_result_kind   (rsp_bus.result_kind),
   .rsp_ipv4_address  (rsp_bus.ipv4_address),
   .rsp_status        (rsp_bus.status),
   .rsp_address_count (rsp_bus.address_count),
   .rsp_last_result   (rsp_bus.last_result),
   .psel              (psel),
   .penable           (penable),
   .pwrite            (pwrite),
   .paddr             (paddr),
   .pwdata            (pwdata),
   .prdata            (prdata)
);

// File: verif/testbench.sv
module testbench;
   import dnsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // run limit, far above the slowest correct run
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [CSR_ADDR_W-1:0] QLEN_ADDR = CSR_ADDR_W'(4 * REG_QUERY_LENGTH);

   // one result item as it leaves the block
   typedef struct packed {
      logic        kind;
      logic [31:0] addr;
      logic [1:0]  status;
      logic [2:0]  count;
      logic        last;
   } dns_item_t;

   // one directed request, with a status typed in where it is obvious
   typedef struct {
      logic [7:0] data;
      logic       eop;
      bit         typed;
      status_type st;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   dnsa_req_if req_bus();
   dnsa_rsp_if rsp_bus();

   dns_a_response_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // address and status items still to come out, oldest first
   dns_item_t   address_status_q[$];
   stim_row_t   directed_rows[$];
   int          error_count = 0;
   int          parsed_items = 0;
   bit          req_burst = 1'b0;

   // query length per phase: reset value, field extremes, below the floor, range ends
   int          phase_qlen[8]   = '{12, 0, 11, 40, 512, 13, 1023, 12};
   int          phase_budget[8] = '{110, 60, 40, 80, 1, 60, 1, 100};

   // parser shadow state
   logic [9:0]  query_len;
   phase_type   prs_phase;
   logic [15:0] prs_count;
   logic [15:0] answers_remaining;
   logic [31:0] field_acc;
   logic [31:0] type_class;
   int          addr_stored;
   status_type  held_status;
   logic        parse_ended;
   int          packet_len;

   function automatic void clear_packet_state();
      prs_phase         = PH_HEADER;
      prs_count         = 16'd0;
      answers_remaining = 16'd0;
      field_acc         = 32'd0;
      type_class        = 32'd0;
      addr_stored       = 0;
      held_status       = ST_OK;
      parse_ended       = 1'b0;
      packet_len        = 0;
   endfunction

   // the first error sticks, later ones are dropped
   function automatic void finish_parse(input status_type st);
      if (held_status == ST_OK) held_status = st;
      parse_ended = 1'b1;
      prs_phase   = PH_DONE;
   endfunction

   function automatic void close_record();
      answers_remaining = answers_remaining - 16'd1;
      if (answers_remaining == 16'd0) finish_parse(ST_OK);
      else prs_phase = PH_NAME;
   endfunction

   // advance the shadow parser by one response byte, queue the items it yields
   function automatic void parse_dns_byte(input logic [7:0] b, input logic eop);
      logic [9:0] eff_len;
      status_type final_st;
      if (!parse_ended && packet_len < MAX_PACKET_BYTES_DEF) begin
         parsed_items++;
         case (prs_phase)
            PH_HEADER: begin
               if (prs_count == ANCOUNT_HI_BYTE || prs_count == ANCOUNT_LO_BYTE)
                  answers_remaining = {answers_remaining[7:0], b};
               prs_count++;
               if (prs_count >= HDR_BYTES) begin
                  if (answers_remaining == 16'd0) begin
                     finish_parse(ST_NOANS);
                  end else begin
                     // a short query length acts as a bare header
                     eff_len   = (query_len < MIN_QUERY_LEN) ? MIN_QUERY_LEN : query_len;
                     prs_count = 16'(eff_len) - HDR_BYTES;
                     prs_phase = (prs_count == 16'd0) ? PH_NAME : PH_QSKIP;
                  end
               end
            end
            PH_QSKIP: begin
               prs_count--;
               if (prs_count == 16'd0) prs_phase = PH_NAME;
            end
            PH_NAME: begin
               if (b == 8'h00) begin
                  prs_phase  = PH_RR;
                  prs_count  = 16'd0;
                  field_acc  = 32'd0;
                  type_class = 32'd0;
               end else if ((b & PTR_MASK) == PTR_MASK) begin
                  prs_phase = PH_PTR;
               end else begin
                  // anything below the pointer mark is a label length
                  prs_phase = PH_LABEL;
                  prs_count = {8'h00, b};
               end
            end
            PH_LABEL: begin
               prs_count--;
               if (prs_count == 16'd0) prs_phase = PH_NAME;
            end
            PH_PTR: begin
               prs_phase  = PH_RR;
               prs_count  = 16'd0;
               field_acc  = 32'd0;
               type_class = 32'd0;
            end
            PH_RR: begin
               if (prs_count < TYPE_CLASS_END) type_class = {type_class[23:0], b};
               else if (prs_count >= RDLENGTH_START) field_acc = {16'h0, field_acc[7:0], b};
               prs_count++;
               if (prs_count >= RR_FIXED_BYTES) begin
                  if (type_class == TYPE_A_CLASS_IN) begin
                     if (field_acc != A_RDLENGTH) begin
                        finish_parse(ST_BADLEN);
                     end else begin
                        prs_phase = PH_ADDR;
                        prs_count = 16'd0;
                        field_acc = 32'd0;
                     end
                  end else if (field_acc == 32'd0) begin
                     close_record();
                  end else begin
                     prs_phase = PH_RSKIP;
                     prs_count = field_acc[15:0];
                  end
               end
            end
            PH_ADDR: begin
               field_acc = {field_acc[23:0], b};
               prs_count++;
               if (prs_count >= ADDR_BYTES) begin
                  // addresses past the limit are parsed but not reported
                  if (addr_stored < MAX_ADDRESSES_DEF) begin
                     addr_stored++;
                     address_status_q.push_back({KIND_ADDR, field_acc, ST_OK,
                                                 3'(addr_stored), 1'b0});
                  end
                  close_record();
               end
            end
            PH_RSKIP: begin
               prs_count--;
               if (prs_count == 16'd0) close_record();
            end
            default: ;
         endcase
      end
      if (packet_len < 32'hffff) packet_len++;

      // last byte always closes the packet with one status item
      if (eop) begin
         final_st = held_status;
         if (final_st == ST_OK && !parse_ended) final_st = ST_TRUNC;
         address_status_q.push_back({KIND_STATUS, 32'h0, final_st, 3'(addr_stored), 1'b1});
         clear_packet_state();
      end
   endfunction

   function automatic void report_mismatch(input string field, input logic [31:0] want,
                                           input logic [31:0] got);
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      error_count++;
   endfunction

   task automatic add_row(input logic [7:0] data, input logic eop, input bit typed,
                          input status_type st);
      stim_row_t row;
      row.data  = data;
      row.eop   = eop;
      row.typed = typed;
      row.st    = st;
      directed_rows.push_back(row);
   endtask

   // present one request after a random gap, predict once it is taken
   task automatic send_byte(input logic [7:0] b, input logic eop, input bit typed,
                            input status_type st);
      int gap;
      int pick;
      if (req_burst) begin
         gap = 0;
      end else begin
         pick = $urandom_range(0, 99);
         gap  = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.end_of_packet <= eop;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      parse_dns_byte(b, eop);
      // directed rows carry their status by hand
      if (typed) begin
         void'(address_status_q.pop_back());
         address_status_q.push_back({KIND_STATUS, 32'h0, st, 3'd0, 1'b1});
      end
   endtask

   // one apb transfer: setup, then access until pready
   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= wr;
      paddr   <= QLEN_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_query_length(input logic [9:0] want);
      logic [31:0] rd;
      csr_access(1'b0, 32'h0, rd);
      if (rd !== {22'h0, want}) report_mismatch("query_length readback", {22'h0, want}, rd);
   endtask

   // stop feeding, let every pending item out, then let the pipeline settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (address_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side stall pattern: short stalls, a few long ones, stretches with none
   initial begin
      int hold;
      int pick;
      bit level;
      hold  = 0;
      level = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               level = 1'b1;
               hold  = $urandom_range(100, 300);
            end else if (pick < 60) begin
               level = 1'b1;
               hold  = $urandom_range(1, 12);
            end else if (pick < 95) begin
               level = 1'b0;
               hold  = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               hold  = $urandom_range(8, 40);
            end
         end
         hold--;
         rsp_bus.ready <= level;
      end
   end

   // compare every accepted item against the oldest prediction
   always @(posedge clock) begin
      dns_item_t got;
      dns_item_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = {rsp_bus.result_kind, rsp_bus.ipv4_address, rsp_bus.status,
                rsp_bus.address_count, rsp_bus.last_result};
         if (address_status_q.size() == 0) begin
            $display("%0t ns: unexpected item, expected none actual %0h", $time, got);
            error_count++;
         end else begin
            want = address_status_q.pop_front();
            if (got.kind !== want.kind) report_mismatch("result_kind", want.kind, got.kind);
            if (got.addr !== want.addr) report_mismatch("ipv4_address", want.addr, got.addr);
            if (got.status !== want.status) report_mismatch("status", want.status, got.status);
            if (got.count !== want.count)
               report_mismatch("address_count", want.count, got.count);
            if (got.last !== want.last) report_mismatch("last_result", want.last, got.last);
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [7:0]  pkt[$];
      logic [15:0] ancount;
      logic [31:0] tc_word;
      logic [9:0]  eff;
      logic [31:0] rd;
      int          ph_idx;
      int          phase_end;
      int          shape;
      int          n_ans;
      int          ans;
      int          len;
      int          kind;
      int          rdlen;
      int          cut;
      int          j;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.data_byte     <= 8'h00;
      req_bus.end_of_packet <= 1'b0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= 32'h0;
      query_len = MIN_QUERY_LEN;
      clear_packet_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register comes out of reset at the bare header length
      check_query_length(MIN_QUERY_LEN);

      // lone byte ending the packet: truncated with nothing stored
      add_row(8'hff, 1'b1, 1'b1, ST_TRUNC);
      // zero answer count with all other header bits set, then ignored trailer
      for (j = 0; j < HDR_BYTES; j++)
         add_row((j == ANCOUNT_HI_BYTE || j == ANCOUNT_LO_BYTE) ? 8'h00 : 8'hff,
                 1'b0, 1'b0, ST_OK);
      add_row(8'h5a, 1'b0, 1'b0, ST_OK);
      add_row(8'ha5, 1'b0, 1'b0, ST_OK);
      add_row(8'h00, 1'b1, 1'b1, ST_NOANS);
      // one answer promised, packet ends right at the header
      for (j = 0; j < HDR_BYTES; j++)
         add_row((j == ANCOUNT_LO_BYTE) ? 8'h01 : 8'h00, j == HDR_BYTES - 1,
                 j == HDR_BYTES - 1, ST_TRUNC);
      foreach (directed_rows[j])
         send_byte(directed_rows[j].data, directed_rows[j].eop, directed_rows[j].typed,
                   directed_rows[j].st);

      for (ph_idx = 0; ph_idx < 8; ph_idx++) begin
         // first phase runs on the reset value, the others reprogram while idle
         if (ph_idx != 0) begin
            drain_results();
            csr_access(1'b1, 32'(phase_qlen[ph_idx]), rd);
            query_len = 10'(phase_qlen[ph_idx]);
            check_query_length(10'(phase_qlen[ph_idx]));
         end
         phase_end = parsed_items + phase_budget[ph_idx];
         do begin
            pkt.delete();
            req_burst = ($urandom_range(0, 3) == 0);
            shape     = $urandom_range(0, 99);
            if (shape < 5) begin
               // plain noise
               len = $urandom_range(1, 40);
               repeat (len) pkt.push_back(8'($urandom));
            end else begin
               n_ans   = (shape < 10) ? 0 : $urandom_range(1, 6);
               ancount = 16'(n_ans);
               // count larger than the answers that follow
               if (shape >= 10 && shape < 15) ancount = 16'($urandom_range(7, 65535));
               for (j = 0; j < HDR_BYTES; j++) pkt.push_back(8'($urandom));
               pkt[ANCOUNT_HI_BYTE] = ancount[15:8];
               pkt[ANCOUNT_LO_BYTE] = ancount[7:0];
               // echoed question, random content
               eff = (query_len < MIN_QUERY_LEN) ? MIN_QUERY_LEN : query_len;
               while (pkt.size() < eff && pkt.size() <= 700) pkt.push_back(8'($urandom));
               for (ans = 0; ans < n_ans && pkt.size() <= 700; ans++) begin
                  // owner name: a few labels, some long, then root or pointer
                  repeat ($urandom_range(0, 3)) begin
                     len = ($urandom_range(0, 99) < 4) ? $urandom_range(64, 191)
                                                       : $urandom_range(1, 12);
                     pkt.push_back(8'(len));
                     repeat (len) pkt.push_back(8'($urandom));
                  end
                  if ($urandom_range(0, 9) < 6) begin
                     pkt.push_back(8'h00);
                  end else begin
                     pkt.push_back(8'($urandom_range(192, 255)));
                     pkt.push_back(8'($urandom));
                  end
                  // mostly a records, some one bit off, some anything
                  kind    = $urandom_range(0, 99);
                  tc_word = (kind < 70) ? TYPE_A_CLASS_IN :
                            (kind < 80) ? (TYPE_A_CLASS_IN ^ (32'h1 << $urandom_range(0, 31))) :
                                          32'($urandom);
                  for (j = 3; j >= 0; j--) pkt.push_back(tc_word[8*j +: 8]);
                  repeat (4) pkt.push_back(8'($urandom));
                  if (kind < 70)
                     rdlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : 4;
                  else
                     rdlen = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 12);
                  pkt.push_back(8'(rdlen >> 8));
                  pkt.push_back(8'(rdlen));
                  for (j = 0; j < rdlen && pkt.size() <= 700; j++) pkt.push_back(8'($urandom));
               end
               // bytes after the last answer
               if ($urandom_range(0, 4) == 0)
                  repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
            end
            // oversized packets end just past the size cap, some others end early
            if (pkt.size() > 600) cut = $urandom_range(513, 600);
            else if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, pkt.size());
            else cut = pkt.size();
            while (pkt.size() > cut) void'(pkt.pop_back());
            for (j = 0; j < pkt.size(); j++)
               send_byte(pkt[j], j == pkt.size() - 1, 1'b0, ST_OK);
         end while (parsed_items < phase_end);
      end

      drain_results();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/dnsa_pkg.sv
rtl/dnsa_if.sv
rtl/dnsa_front.sv
rtl/dnsa_queue.sv
rtl/dnsa_back.sv
rtl/dns_a_response_parser.sv
rtl/dnsa_checker.sv
verif/testbench.sv
